// ===== rtl/mhpq_pkg.sv =====
// Shared types and codes for the max-heap priority queue unit.
package mhpq_pkg;

	localparam logic [2:0] CMD_INSERT  = 3'd0;
	localparam logic [2:0] CMD_POP_MAX = 3'd1;
	localparam logic [2:0] CMD_DELETE  = 3'd2;
	localparam logic [2:0] CMD_REPLACE = 3'd3;
	localparam logic [2:0] CMD_KTH     = 3'd4;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_EMPTY  = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;
	localparam logic [1:0] ST_BADPOS = 2'd3;

	typedef enum logic [4:0] {
		OP_NOP,
		OP_LOAD,
		OP_SET_ST,
		OP_INS_START,
		OP_RD_POS,
		OP_TAKE,
		OP_LAST,
		OP_REPL,
		OP_RD_PARENT,
		OP_UP_MOVE,
		OP_WR_KEY,
		OP_RD_LEFT,
		OP_LCMP,
		OP_RCMP,
		OP_DN_MOVE,
		OP_NEXT_K,
		OP_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic [1:0] st;
	} dp_cmd_t;

	typedef struct packed {
		logic [2:0] cmd;
		logic       full;
		logic       empty;
		logic       bad_pos;
		logic       bad_k;
		logic       idx_zero;
		logic       up_gt;
		logic       l_in;
		logic       r_in;
		logic       big_self;
		logic       more_k;
		logic       hole_last;
	} dp_stat_t;

endpackage

// ===== rtl/mhpq_dp.sv =====
// Datapath of the heap unit: key store, sift registers and result register.
module mhpq_dp #(
	parameter int HEAP_DEPTH = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mhpq_pkg::dp_cmd_t     dcmd,
	output mhpq_pkg::dp_stat_t    dstat,
	input  logic [2:0]            cmd,
	input  logic signed [31:0]    key_value,
	input  logic [9:0]            position,
	input  logic [10:0]           rank_k,
	output logic signed [31:0]    result_key,
	output logic [1:0]            status,
	output logic [10:0]           entry_count_out
);
	import mhpq_pkg::*;

	localparam int AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
	localparam int CW = $clog2(HEAP_DEPTH + 1);
	localparam int XW = AW + 2;

	logic signed [31:0] mem [HEAP_DEPTH];
	logic signed [31:0] rdata_s1;

	logic [2:0]         cmd_q;
	logic signed [31:0] key_q;
	logic [9:0]         pos_q;
	logic [10:0]        k_q;
	logic [CW-1:0]      cnt_q;
	logic [AW-1:0]      idx_q;
	logic [AW-1:0]      big_q;
	logic signed [31:0] bigkey_q;
	logic signed [31:0] res_q;
	logic [1:0]         st_q;

	logic [AW-1:0]      parent;
	logic [AW-1:0]      pidx;
	logic [XW-1:0]      lidx;
	logic [XW-1:0]      ridx;
	logic [AW-1:0]      raddr;
	logic               we;
	logic signed [31:0] wdata;

	assign parent = (idx_q - AW'(1)) >> 1;
	assign pidx   = AW'(pos_q);
	assign lidx   = {1'b0, idx_q, 1'b1};
	assign ridx   = lidx + XW'(1);

	assign dstat.cmd       = cmd_q;
	assign dstat.full      = (cnt_q == CW'(HEAP_DEPTH));
	assign dstat.empty     = (cnt_q == '0);
	assign dstat.bad_pos   = (32'(pos_q) >= 32'(cnt_q));
	assign dstat.bad_k     = (k_q == '0) || (32'(k_q) > 32'(cnt_q));
	assign dstat.idx_zero  = (idx_q == '0);
	assign dstat.up_gt     = (key_q > rdata_s1);
	assign dstat.l_in      = (lidx < XW'(cnt_q));
	assign dstat.r_in      = (ridx < XW'(cnt_q));
	assign dstat.big_self  = (big_q == idx_q);
	assign dstat.more_k    = (k_q > 11'd1);
	assign dstat.hole_last = ((32'(pos_q) + 32'd1) < 32'(cnt_q));

	always_comb begin
		raddr = idx_q;
		we    = 1'b0;
		wdata = key_q;
		unique case (dcmd.op)
			OP_RD_POS:    raddr = pidx;
			OP_TAKE:      raddr = AW'(cnt_q - CW'(1));
			OP_RD_PARENT: raddr = parent;
			OP_RD_LEFT:   raddr = AW'(lidx);
			OP_LCMP:      raddr = AW'(ridx);
			OP_UP_MOVE: begin
				we    = 1'b1;
				wdata = rdata_s1;
			end
			OP_DN_MOVE: begin
				we    = 1'b1;
				wdata = bigkey_q;
			end
			OP_WR_KEY:    we = 1'b1;
			default:      raddr = idx_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[idx_q] <= wdata;
		end
		rdata_s1 <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			unique case (dcmd.op)
				OP_INS_START: cnt_q <= cnt_q + CW'(1);
				OP_TAKE:      cnt_q <= cnt_q - CW'(1);
				default:      cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (dcmd.op)
			OP_LOAD: begin
				cmd_q <= cmd;
				key_q <= key_value;
				pos_q <= (cmd == CMD_POP_MAX || cmd == CMD_KTH) ? 10'd0 : position;
				k_q   <= rank_k;
				res_q <= '0;
				st_q  <= ST_OK;
			end
			OP_SET_ST:    st_q <= dcmd.st;
			OP_INS_START: idx_q <= AW'(cnt_q);
			OP_TAKE:      res_q <= rdata_s1;
			OP_LAST: begin
				key_q <= rdata_s1;
				idx_q <= pidx;
			end
			OP_REPL:      idx_q <= pidx;
			OP_UP_MOVE:   idx_q <= parent;
			OP_LCMP: begin
				if (rdata_s1 > key_q) begin
					big_q    <= AW'(lidx);
					bigkey_q <= rdata_s1;
				end else begin
					big_q    <= idx_q;
					bigkey_q <= key_q;
				end
			end
			OP_RCMP: begin
				if (rdata_s1 > bigkey_q) begin
					big_q    <= AW'(ridx);
					bigkey_q <= rdata_s1;
				end
			end
			OP_DN_MOVE:   idx_q <= big_q;
			OP_NEXT_K:    k_q <= k_q - 11'd1;
			OP_OUT: begin
				result_key      <= res_q;
				status          <= st_q;
				entry_count_out <= 11'(cnt_q);
			end
			default:      idx_q <= idx_q;
		endcase
	end

endmodule

// ===== rtl/mhpq_ctrl.sv =====
// Controller state machine that sequences heap commands over the datapath.
module mhpq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	input  mhpq_pkg::dp_stat_t dstat,
	output mhpq_pkg::dp_cmd_t  dcmd
);
	import mhpq_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_DECODE, S_RM_RD, S_RM_TAKE, S_RM_LAST, S_FIX, S_FIX_CMP,
		S_UP_RD, S_UP_CMP, S_DN_L, S_DN_LC, S_DN_RC, S_DN_MOV, S_DONE, S_FIN
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		dcmd.op = OP_NOP;
		dcmd.st = ST_OK;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					dcmd.op = OP_LOAD;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_FIN;
				unique case (dstat.cmd) inside
					CMD_INSERT: begin
						if (dstat.full) begin
							dcmd.op = OP_SET_ST;
							dcmd.st = ST_FULL;
						end else begin
							dcmd.op = OP_INS_START;
							state_d = S_UP_RD;
						end
					end
					CMD_POP_MAX: begin
						if (dstat.empty) begin
							dcmd.op = OP_SET_ST;
							dcmd.st = ST_EMPTY;
						end else begin
							state_d = S_RM_RD;
						end
					end
					CMD_DELETE, CMD_REPLACE: begin
						if (dstat.empty) begin
							dcmd.op = OP_SET_ST;
							dcmd.st = ST_EMPTY;
						end else if (dstat.bad_pos) begin
							dcmd.op = OP_SET_ST;
							dcmd.st = ST_BADPOS;
						end else if (dstat.cmd == CMD_DELETE) begin
							state_d = S_RM_RD;
						end else begin
							dcmd.op = OP_REPL;
							state_d = S_FIX;
						end
					end
					CMD_KTH: begin
						if (dstat.bad_k) begin
							dcmd.op = OP_SET_ST;
							dcmd.st = ST_EMPTY;
						end else begin
							state_d = S_RM_RD;
						end
					end
					default: state_d = S_FIN;
				endcase
			end
			S_RM_RD: begin
				dcmd.op = OP_RD_POS;
				state_d = S_RM_TAKE;
			end
			S_RM_TAKE: begin
				dcmd.op = OP_TAKE;
				state_d = dstat.hole_last ? S_RM_LAST : S_DONE;
			end
			S_RM_LAST: begin
				dcmd.op = OP_LAST;
				state_d = S_FIX;
			end
			S_FIX: begin
				if (dstat.idx_zero) begin
					state_d = S_DN_L;
				end else begin
					dcmd.op = OP_RD_PARENT;
					state_d = S_FIX_CMP;
				end
			end
			S_FIX_CMP: begin
				if (dstat.up_gt) begin
					dcmd.op = OP_UP_MOVE;
					state_d = S_UP_RD;
				end else begin
					state_d = S_DN_L;
				end
			end
			S_UP_RD: begin
				if (dstat.idx_zero) begin
					dcmd.op = OP_WR_KEY;
					state_d = S_DONE;
				end else begin
					dcmd.op = OP_RD_PARENT;
					state_d = S_UP_CMP;
				end
			end
			S_UP_CMP: begin
				if (dstat.up_gt) begin
					dcmd.op = OP_UP_MOVE;
					state_d = S_UP_RD;
				end else begin
					dcmd.op = OP_WR_KEY;
					state_d = S_DONE;
				end
			end
			S_DN_L: begin
				if (dstat.l_in) begin
					dcmd.op = OP_RD_LEFT;
					state_d = S_DN_LC;
				end else begin
					dcmd.op = OP_WR_KEY;
					state_d = S_DONE;
				end
			end
			S_DN_LC: begin
				dcmd.op = OP_LCMP;
				state_d = dstat.r_in ? S_DN_RC : S_DN_MOV;
			end
			S_DN_RC: begin
				dcmd.op = OP_RCMP;
				state_d = S_DN_MOV;
			end
			S_DN_MOV: begin
				if (dstat.big_self) begin
					dcmd.op = OP_WR_KEY;
					state_d = S_DONE;
				end else begin
					dcmd.op = OP_DN_MOVE;
					state_d = S_DN_L;
				end
			end
			S_DONE: begin
				if (dstat.cmd == CMD_KTH && dstat.more_k) begin
					dcmd.op = OP_NEXT_K;
					state_d = S_RM_RD;
				end else begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (!(out_valid_q && out_stall)) begin
					dcmd.op = OP_OUT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (dcmd.op == OP_OUT) begin
				out_valid_q <= 1'b1;
			end
		end
	end

endmodule

// ===== rtl/max_heap_priority_queue_unit.sv =====
// Top level of the binary max-heap priority queue unit.
//
//  channel  direction  handshake            payload
//  request  in         in_valid / in_stall  cmd, key_value, position, rank_k
//  result   out        out_valid / out_stall  result_key, status, entry_count_out
//
// One request at a time; a sift up walks each heap level with a parent read and
// a compare or move, a sift down with a left read, a left compare, a right
// compare (if there is a right child) and a move. Kth largest repeats the
// removal rank_k times. The registered read of the key store sets the
// per-level cost. Reset clears only the entry count, FSM state and out_valid. A
// stalled result holds the finished next request in its final state.
module max_heap_priority_queue_unit #(
	parameter int HEAP_DEPTH = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         cmd,
	input  logic signed [31:0] key_value,
	input  logic [9:0]         position,
	input  logic [10:0]        rank_k,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] result_key,
	output logic [1:0]         status,
	output logic [10:0]        entry_count_out
);
	import mhpq_pkg::*;

	dp_cmd_t  dcmd;
	dp_stat_t dstat;

	mhpq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.dstat     (dstat),
		.dcmd      (dcmd)
	);

	mhpq_dp #(
		.HEAP_DEPTH (HEAP_DEPTH)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.dcmd            (dcmd),
		.dstat           (dstat),
		.cmd             (cmd),
		.key_value       (key_value),
		.position        (position),
		.rank_k          (rank_k),
		.result_key      (result_key),
		.status          (status),
		.entry_count_out (entry_count_out)
	);

endmodule
